FILE: sv/bdrf_pkg.sv
// Shared types, widths and register codes of the bond distance range filter.
package bdrf_pkg;

   // Field widths of the input and result words.
   localparam int SITE_W      = 6;
   localparam int COORD_W     = 32;
   localparam int DIST_W      = 31;
   localparam int RANGE_END_W = 7;
   localparam int MASK_W      = 64;
   localparam int AXES        = 3;

   // Site count and the self-pair threshold in raw Q16.16 units.
   localparam int MAX_SITES = 64;
   localparam int SELF_EPS  = 0;

   // Configuration port geometry: 64-bit data, registers every 8 bytes.
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_W  = 3;

   // Square root pipeline: a 64-bit radicand gives a 32-bit root.
   localparam int RAD_W                = 64;
   localparam int ROOT_BITS            = RAD_W / 2;
   localparam int ROOT_REM_W           = ROOT_BITS + 3;
   localparam int ROOT_STEPS_PER_STAGE = 2;
   localparam int ROOT_STAGES          = ROOT_BITS / ROOT_STEPS_PER_STAGE;

   // Reset values.
   localparam logic [DIST_W-1:0]      MAX_DISTANCE_RESET = DIST_W'(327680);
   localparam logic [RANGE_END_W-1:0] RANGE_END_RESET    = RANGE_END_W'(64);

   // Register index, taken from paddr[5:3].
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ANCHOR_X     = 3'd0,
      REG_ANCHOR_Y     = 3'd1,
      REG_ANCHOR_Z     = 3'd2,
      REG_MIN_DISTANCE = 3'd3,
      REG_MAX_DISTANCE = 3'd4,
      REG_RANGE_FIRST  = 3'd5,
      REG_RANGE_END    = 3'd6,
      REG_SKIP_MASK    = 3'd7
   } bdrf_reg_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [AXES-1:0][COORD_W-1:0] anchor;
      logic [DIST_W-1:0]            min_distance;
      logic [DIST_W-1:0]            max_distance;
      logic [SITE_W-1:0]            range_first;
      logic [RANGE_END_W-1:0]       range_end;
      logic [MASK_W-1:0]            skip_mask;
   } bdrf_cfg_type;

   // Payload that rides along the pipeline with each word.
   typedef struct packed {
      logic [SITE_W-1:0]            site;
      logic [AXES-1:0][COORD_W-1:0] delta;
   } bdrf_item_type;

   // State of the digit-by-digit square root.
   typedef struct packed {
      logic [RAD_W-1:0]      rad;
      logic [ROOT_BITS-1:0]  root;
      logic [ROOT_REM_W-1:0] rem;
   } bdrf_root_type;

   // One root bit: bring down two radicand bits and try to subtract 4r+1.
   function automatic bdrf_root_type root_step(input bdrf_root_type st);
      bdrf_root_type         nx;
      logic [ROOT_REM_W-1:0] rem_sh;
      logic [ROOT_REM_W-1:0] trial;
      rem_sh = {st.rem[ROOT_REM_W-3:0], st.rad[RAD_W-1 -: 2]};
      trial  = {1'b0, st.root, 2'b01};
      nx.rad = {st.rad[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         nx.rem  = rem_sh - trial;
         nx.root = {st.root[ROOT_BITS-2:0], 1'b1};
      end else begin
         nx.rem  = rem_sh;
         nx.root = {st.root[ROOT_BITS-2:0], 1'b0};
      end
      return nx;
   endfunction

endpackage

FILE: sv/bdrf_csr.sv
// Configuration register file behind the APB-style port.
module bdrf_csr import bdrf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output bdrf_cfg_type          cfg
);

   bdrf_cfg_type cfg_ff;
   bdrf_cfg_type cfg_in;
   bdrf_reg_type reg_idx;
   logic         wr_en;

   // The register index is the 8-byte word address.
   assign reg_idx = bdrf_reg_type'(paddr[CSR_ADDR_W-1 -: CSR_IDX_W]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // Write decode: only the addressed register takes the new word.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_ANCHOR_X:     cfg_in.anchor[0]    = pwdata[COORD_W-1:0];
            REG_ANCHOR_Y:     cfg_in.anchor[1]    = pwdata[COORD_W-1:0];
            REG_ANCHOR_Z:     cfg_in.anchor[2]    = pwdata[COORD_W-1:0];
            REG_MIN_DISTANCE: cfg_in.min_distance = pwdata[DIST_W-1:0];
            REG_MAX_DISTANCE: cfg_in.max_distance = pwdata[DIST_W-1:0];
            REG_RANGE_FIRST:  cfg_in.range_first  = pwdata[SITE_W-1:0];
            REG_RANGE_END:    cfg_in.range_end    = pwdata[RANGE_END_W-1:0];
            REG_SKIP_MASK:    cfg_in.skip_mask    = pwdata[MASK_W-1:0];
         endcase
      end
   end

   // Register storage with its reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.anchor       <= '0;
         cfg_ff.min_distance <= '0;
         cfg_ff.max_distance <= MAX_DISTANCE_RESET;
         cfg_ff.range_first  <= '0;
         cfg_ff.range_end    <= RANGE_END_RESET;
         cfg_ff.skip_mask    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux, fields zero-extended to the bus width.
   always_comb begin
      unique case (reg_idx)
         REG_ANCHOR_X:     prdata = CSR_DATA_W'(cfg_ff.anchor[0]);
         REG_ANCHOR_Y:     prdata = CSR_DATA_W'(cfg_ff.anchor[1]);
         REG_ANCHOR_Z:     prdata = CSR_DATA_W'(cfg_ff.anchor[2]);
         REG_MIN_DISTANCE: prdata = CSR_DATA_W'(cfg_ff.min_distance);
         REG_MAX_DISTANCE: prdata = CSR_DATA_W'(cfg_ff.max_distance);
         REG_RANGE_FIRST:  prdata = CSR_DATA_W'(cfg_ff.range_first);
         REG_RANGE_END:    prdata = CSR_DATA_W'(cfg_ff.range_end);
         REG_SKIP_MASK:    prdata = CSR_DATA_W'(cfg_ff.skip_mask);
      endcase
   end

endmodule

FILE: sv/bdrf_front.sv
// Front pipeline: site filter and deltas, squares, and the sum of squares.
module bdrf_front import bdrf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  bdrf_cfg_type              cfg,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [SITE_W-1:0]         in_site,
   input  logic [AXES-1:0][COORD_W-1:0] in_pos,
   output logic                      out_valid,
   input  logic                      out_ready,
   output bdrf_item_type             out_item,
   output logic [RAD_W-1:0]          out_sum
);

   localparam int SQ_W = 2 * DIST_W;

   logic                  s1_valid_ff, s1_valid_in, s1_ready;
   bdrf_item_type         s1_item_ff, s1_item_in;
   logic [DIST_W-1:0]     s1_mag_ff [AXES];
   logic [DIST_W-1:0]     s1_mag_in [AXES];

   logic                  s2_valid_ff, s2_ready;
   bdrf_item_type         s2_item_ff;
   logic [SQ_W-1:0]       s2_sq_ff [AXES];
   logic [SQ_W-1:0]       s2_sq_in [AXES];

   logic                  s3_valid_ff, s3_ready;
   bdrf_item_type         s3_item_ff;
   logic [RAD_W-1:0]      s3_sum_ff, s3_sum_in;

   logic signed [COORD_W:0] dlt [AXES];
   logic [COORD_W:0]        absd [AXES];
   logic                    too_far;
   logic                    site_ok;

   // A stage loads when it is empty or its word moves on.
   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // Stage 1: exact 33-bit deltas, magnitudes, component early out, site checks.
   always_comb begin
      too_far = 1'b0;
      for (int a = 0; a < AXES; a++) begin
         dlt[a] = $signed({in_pos[a][COORD_W-1], in_pos[a]})
                - $signed({cfg.anchor[a][COORD_W-1], cfg.anchor[a]});
         absd[a] = dlt[a][COORD_W] ? (COORD_W+1)'(-dlt[a]) : (COORD_W+1)'(dlt[a]);
         if (absd[a] > (COORD_W+1)'(cfg.max_distance)) begin
            too_far = 1'b1;
         end
         s1_mag_in[a]       = absd[a][DIST_W-1:0];
         s1_item_in.delta[a] = dlt[a][COORD_W-1:0];
      end
      s1_item_in.site = in_site;
      site_ok = (in_site >= cfg.range_first)
             && ({1'b0, in_site} < cfg.range_end)
             && ({1'b0, in_site} < RANGE_END_W'(MAX_SITES))
             && !cfg.skip_mask[in_site];
      s1_valid_in = in_valid && site_ok && !too_far;
   end

   // Stage 2: one 31 by 31 square per axis.
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         s2_sq_in[a] = SQ_W'(s1_mag_ff[a]) * SQ_W'(s1_mag_ff[a]);
      end
   end

   // Stage 3: sum of squares, below 2^64 since each magnitude is below 2^31.
   assign s3_sum_in = RAD_W'(s2_sq_ff[0]) + RAD_W'(s2_sq_ff[1]) + RAD_W'(s2_sq_ff[2]);

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= s1_valid_in;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_item_ff <= s1_item_in;
         s1_mag_ff  <= s1_mag_in;
      end
      if (s2_ready) begin
         s2_item_ff <= s1_item_ff;
         s2_sq_ff   <= s2_sq_in;
      end
      if (s3_ready) begin
         s3_item_ff <= s2_item_ff;
         s3_sum_ff  <= s3_sum_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_item  = s3_item_ff;
   assign out_sum   = s3_sum_ff;

endmodule

FILE: sv/bdrf_sqrt.sv
// Pipelined integer square root, a fixed number of root bits per stage.
module bdrf_sqrt import bdrf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  bdrf_item_type        in_item,
   input  logic [RAD_W-1:0]     in_sum,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bdrf_item_type        out_item,
   output logic [ROOT_BITS-1:0] out_root
);

   logic [ROOT_STAGES-1:0] valid_ff;
   logic [ROOT_STAGES:0]   rdy;
   bdrf_item_type          item_ff [ROOT_STAGES];
   bdrf_root_type          st_ff   [ROOT_STAGES];
   bdrf_root_type          st_in   [ROOT_STAGES];
   bdrf_root_type          st_src  [ROOT_STAGES];
   bdrf_item_type          item_src [ROOT_STAGES];
   logic [ROOT_STAGES-1:0] valid_src;

   // Backpressure chain from the output back to the input.
   assign rdy[ROOT_STAGES] = out_ready;
   assign in_ready         = rdy[0];

   // Stage sources: the first stage starts a fresh root from the sum.
   always_comb begin
      st_src[0].rad  = in_sum;
      st_src[0].root = '0;
      st_src[0].rem  = '0;
      item_src[0]    = in_item;
      valid_src[0]   = in_valid;
      for (int k = 1; k < ROOT_STAGES; k++) begin
         st_src[k]    = st_ff[k-1];
         item_src[k]  = item_ff[k-1];
         valid_src[k] = valid_ff[k-1];
      end
   end

   for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stage
      assign rdy[k] = !valid_ff[k] || rdy[k+1];

      // Retire this stage's root bits.
      always_comb begin
         st_in[k] = st_src[k];
         for (int s = 0; s < ROOT_STEPS_PER_STAGE; s++) begin
            st_in[k] = root_step(st_in[k]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            valid_ff[k] <= valid_src[k];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            st_ff[k]   <= st_in[k];
            item_ff[k] <= item_src[k];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_STAGES-1];
   assign out_item  = item_ff[ROOT_STAGES-1];
   assign out_root  = st_ff[ROOT_STAGES-1].root;

endmodule

FILE: sv/bond_distance_range_filter_unit.sv
// Bond distance range filter: anchor-to-site distance cutoff with a
// pipelined square root. One site word enters per clock while req_stall
// is low; a word that yields a bond passes one stage for the site checks
// and deltas, one for the squares, one for the sum, 16 square root stages
// at two root bits each, and the output register. Rejected sites leave a
// bubble and produce no word. Stalls on the result side fill bubbles first
// and only then hold off the input. Configuration is read live by the
// datapath and should be written while no word is in flight.
module bond_distance_range_filter_unit import bdrf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // Site input.
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [SITE_W-1:0]         req_site_index,
   input  logic signed [COORD_W-1:0] req_pos_x,
   input  logic signed [COORD_W-1:0] req_pos_y,
   input  logic signed [COORD_W-1:0] req_pos_z,
   // Bond output.
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [SITE_W-1:0]         rsp_bond_site,
   output logic signed [COORD_W-1:0] rsp_delta_x,
   output logic signed [COORD_W-1:0] rsp_delta_y,
   output logic signed [COORD_W-1:0] rsp_delta_z,
   output logic [DIST_W-1:0]         rsp_bond_length,
   // Configuration port.
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_W-1:0]     paddr,
   input  logic [CSR_DATA_W-1:0]     pwdata,
   output logic [CSR_DATA_W-1:0]     prdata,
   output logic                      pready
);

   bdrf_cfg_type            cfg;
   logic                    fr_in_ready;
   logic [AXES-1:0][COORD_W-1:0] req_pos;
   logic                    fr_valid, fr_ready;
   bdrf_item_type           fr_item;
   logic [RAD_W-1:0]        fr_sum;
   logic                    sq_valid, out_ready;
   bdrf_item_type           sq_item;
   logic [ROOT_BITS-1:0]    sq_root;
   logic                    dist_ok;

   logic                    out_valid_ff, out_valid_in;
   bdrf_item_type           out_item_ff;
   logic [DIST_W-1:0]       out_len_ff;
   logic [COORD_W-1:0]      abs_dx, abs_dy, abs_dz;

   bdrf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_pos = {req_pos_z, req_pos_y, req_pos_x};

   bdrf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (fr_in_ready),
      .in_site   (req_site_index),
      .in_pos    (req_pos),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_item  (fr_item),
      .out_sum   (fr_sum)
   );

   assign req_stall = !fr_in_ready;

   bdrf_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_item   (fr_item),
      .in_sum    (fr_sum),
      .out_valid (sq_valid),
      .out_ready (out_ready),
      .out_item  (sq_item),
      .out_root  (sq_root)
   );

   // Distance window and self-pair rejection on the finished root.
   assign dist_ok = (sq_root >= ROOT_BITS'(cfg.min_distance))
                 && (sq_root <= ROOT_BITS'(cfg.max_distance))
                 && (sq_root > ROOT_BITS'(SELF_EPS));

   // Output register: takes the next word once the current one is gone.
   assign out_ready    = !out_valid_ff || !rsp_stall;
   assign out_valid_in = sq_valid && dist_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         out_item_ff <= sq_item;
         out_len_ff  <= sq_root[DIST_W-1:0];
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_bond_site   = out_item_ff.site;
   assign rsp_delta_x     = $signed(out_item_ff.delta[0]);
   assign rsp_delta_y     = $signed(out_item_ff.delta[1]);
   assign rsp_delta_z     = $signed(out_item_ff.delta[2]);
   assign rsp_bond_length = out_len_ff;

   // Component magnitudes for the checks below.
   assign abs_dx = rsp_delta_x[COORD_W-1] ? COORD_W'(-rsp_delta_x) : COORD_W'(rsp_delta_x);
   assign abs_dy = rsp_delta_y[COORD_W-1] ? COORD_W'(-rsp_delta_y) : COORD_W'(rsp_delta_y);
   assign abs_dz = rsp_delta_z[COORD_W-1] ? COORD_W'(-rsp_delta_z) : COORD_W'(rsp_delta_z);

   // An emitted bond is never the self pair.
   a_not_self: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bond_length > DIST_W'(SELF_EPS)))
      else $error("bond word with a self-pair distance");

   // The floor root is never shorter than any single component.
   a_len_covers_delta: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (abs_dx <= COORD_W'(rsp_bond_length))
                 && (abs_dy <= COORD_W'(rsp_bond_length))
                 && (abs_dz <= COORD_W'(rsp_bond_length)))
      else $error("bond length below a delta component");

   // With the output register empty the whole pipeline can move.
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while the output register is empty");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the bond distance range filter unit.
`timescale 1ns / 1ps

module testbench;
   import bdrf_pkg::*;

   // Depth of the datapath from site word to bond word, and drain margins.
   localparam int PIPE_LATENCY = 20;
   localparam int DRAIN_CYCLES = 2 * PIPE_LATENCY + 8;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int Q_ONE        = 65536;

   // One expected bond word.
   typedef struct packed {
      logic [SITE_W-1:0]  site;
      logic [COORD_W-1:0] dx;
      logic [COORD_W-1:0] dy;
      logic [COORD_W-1:0] dz;
      logic [DIST_W-1:0]  bond_length;
   } bond_word_type;

   logic clock;
   logic reset = 1'b1;

   logic                      req_valid      = 1'b0;
   logic                      req_stall;
   logic [SITE_W-1:0]         req_site_index = '0;
   logic signed [COORD_W-1:0] req_pos_x      = '0;
   logic signed [COORD_W-1:0] req_pos_y      = '0;
   logic signed [COORD_W-1:0] req_pos_z      = '0;

   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [SITE_W-1:0]         rsp_bond_site;
   logic signed [COORD_W-1:0] rsp_delta_x;
   logic signed [COORD_W-1:0] rsp_delta_y;
   logic signed [COORD_W-1:0] rsp_delta_z;
   logic [DIST_W-1:0]         rsp_bond_length;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Shadow of the configuration registers; anchor[0] is x.
   bdrf_cfg_type cfg;

   bond_word_type pending_bonds[$];
   int         mismatches   = 0;
   int         cycle_count  = 0;
   int         req_gap_max  = 16;
   int         rsp_idle_max = 16;
   logic       hold_toggle  = 1'b0;
   logic       hold_seen    = 1'b0;
   int         hold_left    = 0;
   int         stall_left   = 0;

   bond_distance_range_filter_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_site_index  (req_site_index),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_bond_site   (rsp_bond_site),
      .rsp_delta_x     (rsp_delta_x),
      .rsp_delta_y     (rsp_delta_y),
      .rsp_delta_z     (rsp_delta_z),
      .rsp_bond_length (rsp_bond_length),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run-away guard.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Floor of the square root, one root bit per trial from the top down.
   function automatic longint unsigned floor_root(input longint unsigned n);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= n) r = t;
      end
      return r;
   endfunction

   // Works out whether a site forms a bond with the anchor, and the bond word.
   function automatic bit predict_bond(input bdrf_cfg_type c, input logic [SITE_W-1:0] site,
                                       input logic [AXES-1:0][COORD_W-1:0] pos,
                                       output bond_word_type w);
      longint          d[AXES];
      longint unsigned m[AXES];
      longint unsigned sum_sq;
      longint unsigned root_len;
      w = '0;
      if (site < c.range_first || site >= c.range_end || site >= MAX_SITES) return 0;
      if (c.skip_mask[site]) return 0;
      // Any single component beyond the upper bound rules the site out early.
      for (int a = 0; a < AXES; a++) begin
         d[a] = longint'(signed'(pos[a])) - longint'(signed'(c.anchor[a]));
         m[a] = (d[a] < 0) ? -d[a] : d[a];
         if (m[a] > c.max_distance) return 0;
      end
      sum_sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      root_len = floor_root(sum_sq);
      if (root_len < c.min_distance || root_len > c.max_distance) return 0;
      if (root_len <= SELF_EPS) return 0;
      w.site        = site;
      w.dx          = d[0][COORD_W-1:0];
      w.dy          = d[1][COORD_W-1:0];
      w.dz          = d[2][COORD_W-1:0];
      w.bond_length = root_len[DIST_W-1:0];
      return 1;
   endfunction

   function automatic void check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Result side stall: a random pause after each word, plus a long hold on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left = 0;
         hold_seen = hold_toggle;
      end else begin
         if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
         end
         if (rsp_valid && !rsp_stall)
            stall_left = (rsp_idle_max == 0 || $urandom_range(0, 2) == 0) ? 0 :
                         $urandom_range(0, rsp_idle_max);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each accepted bond word with the oldest expectation.
   always @(posedge clock) begin
      bond_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bonds.size() == 0) begin
            $error("unexpected bond word for site %0d", rsp_bond_site);
            mismatches++;
         end else begin
            want = pending_bonds.pop_front();
            check_field("bond_site", want.site, rsp_bond_site);
            check_field("delta_x", longint'(signed'(want.dx)), longint'(rsp_delta_x));
            check_field("delta_y", longint'(signed'(want.dy)), longint'(rsp_delta_y));
            check_field("delta_z", longint'(signed'(want.dz)), longint'(rsp_delta_z));
            check_field("bond_length", want.bond_length, rsp_bond_length);
         end
      end
   end

   // Offers one site word after a random gap and records the bond it should give.
   task automatic send_site(input logic [SITE_W-1:0] site, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
      int         gap;
      bond_word_type w;
      gap = (req_gap_max == 0 || $urandom_range(0, 2) == 0) ? 0 :
            $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_site_index <= site;
      req_pos_x      <= x;
      req_pos_y      <= y;
      req_pos_z      <= z;
      do @(posedge clock); while (req_stall);
      if (predict_bond(cfg, site, {z, y, x}, w)) pending_bonds.push_back(w);
   endtask

   // Stops offering words and lets every bond in flight come out.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_bonds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write: setup cycle, access cycle, then an idle cycle.
   task automatic csr_write(input bdrf_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_ANCHOR_X:     cfg.anchor[0]    = value[COORD_W-1:0];
         REG_ANCHOR_Y:     cfg.anchor[1]    = value[COORD_W-1:0];
         REG_ANCHOR_Z:     cfg.anchor[2]    = value[COORD_W-1:0];
         REG_MIN_DISTANCE: cfg.min_distance = value[DIST_W-1:0];
         REG_MAX_DISTANCE: cfg.max_distance = value[DIST_W-1:0];
         REG_RANGE_FIRST:  cfg.range_first  = value[SITE_W-1:0];
         REG_RANGE_END:    cfg.range_end    = value[RANGE_END_W-1:0];
         REG_SKIP_MASK:    cfg.skip_mask    = value;
         default: ;
      endcase
   endtask

   task automatic write_anchor(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                               input logic [COORD_W-1:0] z);
      csr_write(REG_ANCHOR_X, {{32{x[31]}}, x});
      csr_write(REG_ANCHOR_Y, {{32{y[31]}}, y});
      csr_write(REG_ANCHOR_Z, {{32{z[31]}}, z});
   endtask

   // Reset values: self pair, one raw unit, the 5.0 boundary and truncation.
   task automatic test_reset_values();
      send_site(6'd0, 0, 0, 0);
      send_site(6'd1, 1, 0, 0);
      send_site(6'd2, 5 * Q_ONE, 0, 0);
      send_site(6'd3, 5 * Q_ONE + 1, 0, 0);
      send_site(6'd4, 3 * Q_ONE, -4 * Q_ONE, 0);
      send_site(6'd5, 3 * Q_ONE, -4 * Q_ONE, 1);
      send_site(6'd6, -3 * Q_ONE, -3 * Q_ONE, -3 * Q_ONE);
      send_site(6'd63, -2 * Q_ONE, 2 * Q_ONE, -Q_ONE);
   endtask

   // Anchors at both ends of the coordinate range with the widest bound.
   task automatic test_coordinate_extremes();
      settle();
      write_anchor(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      csr_write(REG_MIN_DISTANCE, 64'd0);
      csr_write(REG_MAX_DISTANCE, 64'h7FFF_FFFF);
      send_site(6'd10, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_site(6'd11, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_site(6'd12, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_site(6'd13, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      settle();
      write_anchor(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_site(6'd14, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_site(6'd15, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
   endtask

   // Site range limits, empty and inverted ranges, and the skip mask.
   task automatic test_site_window();
      settle();
      write_anchor(0, 0, 0);
      csr_write(REG_MAX_DISTANCE, 64'(5 * Q_ONE));
      csr_write(REG_RANGE_FIRST, 64'd10);
      csr_write(REG_RANGE_END, 64'd20);
      csr_write(REG_SKIP_MASK, (64'd1 << 12) | (64'd1 << 63));
      send_site(6'd9, Q_ONE, 0, 0);
      send_site(6'd10, Q_ONE, 0, 0);
      send_site(6'd12, Q_ONE, 0, 0);
      send_site(6'd19, 0, -Q_ONE, 0);
      send_site(6'd20, 0, 0, Q_ONE);
      settle();
      csr_write(REG_RANGE_FIRST, 64'd63);
      csr_write(REG_RANGE_END, 64'd64);
      csr_write(REG_SKIP_MASK, 64'h7FFF_FFFF_FFFF_FFFF);
      send_site(6'd63, 0, 2 * Q_ONE, 0);
      send_site(6'd62, 0, 2 * Q_ONE, 0);
      settle();
      // Inverted range, then an empty one at the bottom.
      csr_write(REG_RANGE_FIRST, 64'd40);
      csr_write(REG_RANGE_END, 64'd5);
      send_site(6'd3, Q_ONE, Q_ONE, 0);
      send_site(6'd40, Q_ONE, Q_ONE, 0);
      settle();
      csr_write(REG_RANGE_FIRST, 64'd0);
      csr_write(REG_RANGE_END, 64'd0);
      send_site(6'd0, Q_ONE, Q_ONE, 0);
      settle();
      csr_write(REG_RANGE_END, 64'd64);
      csr_write(REG_SKIP_MASK, '1);
      send_site(6'd33, Q_ONE, Q_ONE, 0);
   endtask

   // A ring of zero width, then bounds that cross.
   task automatic test_distance_bounds();
      settle();
      csr_write(REG_SKIP_MASK, 64'd0);
      csr_write(REG_MIN_DISTANCE, 64'(2 * Q_ONE));
      csr_write(REG_MAX_DISTANCE, 64'(2 * Q_ONE));
      send_site(6'd21, 0, 0, 2 * Q_ONE);
      send_site(6'd22, 0, 0, 2 * Q_ONE - 1);
      send_site(6'd23, 0, 0, 2 * Q_ONE + 1);
      settle();
      csr_write(REG_MIN_DISTANCE, 64'(3 * Q_ONE));
      send_site(6'd24, 0, 5 * Q_ONE / 2, 0);
   endtask

   // Random site words: mostly near the anchor, some on a bound, some anywhere.
   task automatic send_random_sites(input int count);
      int                         mode;
      int                         ax;
      longint                     lim;
      longint                     off;
      longint                     r;
      logic [AXES-1:0][COORD_W-1:0] pos;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(0, 9);
         lim = longint'(cfg.max_distance) + longint'(cfg.max_distance >> 2) + 2;
         if (mode <= 5) begin
            for (int a = 0; a < AXES; a++) begin
               off = longint'($urandom_range(0, lim));
               if ($urandom_range(0, 1)) off = -off;
               r = longint'(signed'(cfg.anchor[a])) + off;
               pos[a] = r[COORD_W-1:0];
            end
         end else if (mode <= 7) begin
            r = ($urandom_range(0, 1) ? longint'(cfg.min_distance) :
                 longint'(cfg.max_distance)) + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1)) r = -r;
            ax = $urandom_range(0, AXES - 1);
            for (int a = 0; a < AXES; a++) begin
               off = (a == ax) ? r : 0;
               off = longint'(signed'(cfg.anchor[a])) + off;
               pos[a] = off[COORD_W-1:0];
            end
         end else begin
            for (int a = 0; a < AXES; a++) pos[a] = $urandom;
         end
         send_site(SITE_W'($urandom_range(0, 63)), pos[0], pos[1], pos[2]);
      end
   endtask

   // The receiver holds off while words keep coming, so the input stalls.
   task automatic test_stalled_output();
      settle();
      write_anchor($urandom, $urandom, $urandom);
      csr_write(REG_MIN_DISTANCE, 64'd0);
      csr_write(REG_MAX_DISTANCE, 64'd1 << 20);
      csr_write(REG_RANGE_FIRST, 64'd0);
      csr_write(REG_RANGE_END, 64'd64);
      csr_write(REG_SKIP_MASK, 64'd0);
      req_gap_max = 0;
      hold_toggle <= ~hold_toggle;
      send_random_sites(80);
   endtask

   // Phases of random settings with different idle patterns on both sides.
   task automatic test_random_settings();
      int sc;
      logic [DIST_W-1:0] max_d;
      int gap_plan[6]  = '{0, 16, 0, 16, 4, 16};
      int idle_plan[6] = '{0, 16, 16, 0, 4, 16};
      for (int ph = 0; ph < 6; ph++) begin
         settle();
         req_gap_max  = gap_plan[ph];
         rsp_idle_max = idle_plan[ph];
         sc = $urandom_range(4, 31);
         max_d = (sc == 31) ? 31'h7FFF_FFFF : DIST_W'($urandom_range(1, 1 << sc));
         write_anchor($urandom, $urandom, $urandom);
         csr_write(REG_MAX_DISTANCE, 64'(max_d));
         csr_write(REG_MIN_DISTANCE,
                   64'($urandom_range(0, 1) ? 0 : $urandom_range(0, max_d)));
         csr_write(REG_RANGE_FIRST, 64'($urandom_range(0, 16)));
         csr_write(REG_RANGE_END, 64'($urandom_range(48, 64)));
         csr_write(REG_SKIP_MASK, {$urandom, $urandom} & {$urandom, $urandom} &
                                  {$urandom, $urandom});
         send_random_sites(100);
      end
   endtask

   initial begin
      cfg.anchor       = '0;
      cfg.min_distance = '0;
      cfg.max_distance = MAX_DISTANCE_RESET;
      cfg.range_first  = '0;
      cfg.range_end    = RANGE_END_RESET;
      cfg.skip_mask    = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_coordinate_extremes();
      test_site_window();
      test_distance_bounds();
      test_stalled_output();
      test_random_settings();
      settle();
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
